### hdl/lms_pkg.sv
// Shared types and constants for the LED matrix scan frame buffer.
// No dependencies; used by every other file in hdl/ except lms_checker.sv.
package lms_pkg;

	// Request kinds carried on the input tuser field
	typedef enum logic [3:0] {
		REQ_TICK    = 4'd0,
		REQ_SET     = 4'd1,
		REQ_CLEAR   = 4'd2,
		REQ_TOGGLE  = 4'd3,
		REQ_GET     = 4'd4,
		REQ_PUT     = 4'd5,
		REQ_CLR_ALL = 4'd6,
		REQ_SET_ALL = 4'd7,
		REQ_INV_ALL = 4'd8
	} req_t;

	localparam int unsigned ROWS    = 8;
	localparam int unsigned ROW_W   = 8;
	localparam int unsigned COORD_W = 3;

	// Stored row for scan pointer p is p ^ 3: order 3,2,1,0,7,6,5,4
	localparam logic [COORD_W-1:0] SCAN_FLIP = 3'd3;
	localparam logic [ROW_W-1:0]   ROW_FULL  = 8'hFF;
	localparam logic [ROW_W-1:0]   ROW_MSB   = 8'h80;

	// One request word after unpacking
	typedef struct packed {
		req_t               req;
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
		logic               put_value;
	} item_t;

	// One result word
	typedef struct packed {
		logic [ROW_W-1:0] column_data;
		logic             row_shift;
		logic             row_select_bit;
		logic             pixel_was;
	} result_t;

endpackage

### hdl/led_matrix_scan_framebuffer.sv
// Top level of the LED matrix scan frame buffer: stream ports, input and
// output registers. Depends on lms_pkg and lms_frame.
//
// Usage:
//   Requests enter on the s_ group: s_tuser holds the request kind, s_tdata
//   the pixel coordinates and put value. Each request yields exactly one
//   result word on the m_ group, in request order.
//   Pixel requests (set, clear, toggle, get, put) return the pixel's earlier
//   value; a tick returns the row-select bit, a shift pulse flag and the
//   column byte of the scanned row, then advances the scan pointer.
//   Whole-frame requests (clear, set, invert all) return an all-zero word.
// Flow and throughput:
//   A word accepted into the input register is processed combinationally
//   and written to the output register as soon as that register can load;
//   m_tvalid then rises. One word per cycle is sustained while m_tready
//   stays high; no request kind holds the input stage busy.
// Reset:
//   arst_n clears the frame store, the scan pointer and both valid flags.
// Stall:
//   While m_tready is low the output word holds; the input stage still takes
//   one more word, then s_tready drops until the output drains.
module led_matrix_scan_framebuffer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [2:0] pixel_x, [5:3] pixel_y, [6] put_value, [7] zero
	input  logic [3:0]  s_tuser,   // [3:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [0] pixel_was, [1] row_select_bit, [2] row_shift,
	                               // [10:3] column_data, [15:11] zero
);

	lms_pkg::item_t   item_s1;
	logic             valid_s1;
	lms_pkg::result_t res;
	lms_pkg::result_t res_s2;
	logic             valid_s2;
	logic             load_s2;
	logic             commit;

	// Handshake: output loads when empty or draining, input follows
	assign load_s2  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || load_s2;
	assign commit   = valid_s1 && load_s2;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.req       <= lms_pkg::req_t'(s_tuser);
			item_s1.pixel_x   <= s_tdata[2:0];
			item_s1.pixel_y   <= s_tdata[5:3];
			item_s1.put_value <= s_tdata[6];
		end
	end

	lms_frame u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (commit),
		.item   (item_s1),
		.res    (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'd0, res_s2.column_data, res_s2.row_shift,
	                   res_s2.row_select_bit, res_s2.pixel_was};

endmodule

### hdl/lms_frame.sv
// Frame store (8 rows of 8 pixels), scan pointer and the per-request logic.
// Depends on lms_pkg. Result is combinational from the registered request.
module lms_frame (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             commit,
	input  lms_pkg::item_t   item,
	output lms_pkg::result_t res
);

	logic [lms_pkg::ROW_W-1:0]   frame_q [lms_pkg::ROWS];
	logic [lms_pkg::COORD_W-1:0] scan_q;

	logic [lms_pkg::COORD_W-1:0] rd_addr;
	logic [lms_pkg::ROW_W-1:0]   rd_row;
	logic [lms_pkg::ROW_W-1:0]   mask;
	logic                        was;
	logic                        is_tick;

	// Single read port: scanned row on tick, addressed row otherwise
	assign is_tick = (item.req == lms_pkg::REQ_TICK);
	assign rd_addr = is_tick ? (scan_q ^ lms_pkg::SCAN_FLIP) : item.pixel_y;
	assign rd_row  = frame_q[rd_addr];
	assign mask    = lms_pkg::ROW_MSB >> item.pixel_x;
	assign was     = |(rd_row & mask);

	// Result word
	always_comb begin
		res = '0;
		unique case (item.req)
			lms_pkg::REQ_TICK: begin
				res.row_select_bit = (scan_q != '0);
				res.row_shift      = 1'b1;
				res.column_data    = rd_row;
			end
			lms_pkg::REQ_SET, lms_pkg::REQ_CLEAR, lms_pkg::REQ_TOGGLE,
			lms_pkg::REQ_GET, lms_pkg::REQ_PUT: begin
				res.pixel_was = was;
			end
			default: begin
				res = '0;
			end
		endcase
	end

	// State update when the request is committed to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			for (int i = 0; i < lms_pkg::ROWS; i++) frame_q[i] <= '0;
		end else if (commit) begin
			unique case (item.req)
				lms_pkg::REQ_TICK: scan_q <= scan_q + 3'd1;
				lms_pkg::REQ_SET: frame_q[item.pixel_y] <= rd_row | mask;
				lms_pkg::REQ_CLEAR: frame_q[item.pixel_y] <= rd_row & ~mask;
				lms_pkg::REQ_TOGGLE: frame_q[item.pixel_y] <= rd_row ^ mask;
				lms_pkg::REQ_PUT: begin
					frame_q[item.pixel_y] <= item.put_value ? (rd_row | mask)
					                                        : (rd_row & ~mask);
				end
				lms_pkg::REQ_CLR_ALL: begin
					for (int i = 0; i < lms_pkg::ROWS; i++) frame_q[i] <= '0;
				end
				lms_pkg::REQ_SET_ALL: begin
					for (int i = 0; i < lms_pkg::ROWS; i++) frame_q[i] <= lms_pkg::ROW_FULL;
				end
				lms_pkg::REQ_INV_ALL: begin
					for (int i = 0; i < lms_pkg::ROWS; i++) begin
						frame_q[i] <= frame_q[i] ^ lms_pkg::ROW_FULL;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### hdl/lms_checker.sv
// Port-level checks for led_matrix_scan_framebuffer, attached by bind.
// Depends only on the top level's ports.
module lms_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// A stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// A tick never reports a pixel value
	a_tick_no_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> !m_tdata[0])
		else $error("tick word carries pixel_was");

	// Scan fields are zero on every word that is not a tick
	a_scan_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[2] |-> !m_tdata[1] && (m_tdata[10:3] == 8'd0))
		else $error("scan fields set on a non-tick word");

	// Padding bits stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:11] == 5'd0)
		else $error("padding bits of result word not zero");

endmodule

bind led_matrix_scan_framebuffer lms_checker u_lms_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### sim/tb_top.sv
// Self-checking testbench for led_matrix_scan_framebuffer: pixel, whole-frame
// and scan-tick requests, checked word by word against a frame store kept here.
// Depends on hdl/lms_pkg.sv and hdl/led_matrix_scan_framebuffer.sv.
`timescale 1ns / 1ps

// Keeps a shadow frame store and scan pointer, predicts each result word
class matrix_scoreboard;
	logic [lms_pkg::ROW_W-1:0]   rows [lms_pkg::ROWS];
	logic [lms_pkg::COORD_W-1:0] scan_ptr;
	lms_pkg::result_t            due_results [$];
	int unsigned                 fail_count;
	int unsigned                 words_seen;

	function new();
		foreach (rows[i]) rows[i] = '0;
		scan_ptr    = '0;
		fail_count  = 0;
		words_seen  = 0;
	endfunction

	function int unsigned pending();
		return due_results.size();
	endfunction

	task report(input string msg);
		$display("MISMATCH word %0d: %s", words_seen, msg);
		fail_count++;
	endtask

	// Apply one accepted request to the shadow state, queue its result
	function void note_request(input lms_pkg::item_t it);
		lms_pkg::result_t          r;
		logic [lms_pkg::ROW_W-1:0] mask;
		logic [lms_pkg::ROW_W-1:0] row;
		r    = '0;
		mask = lms_pkg::ROW_MSB >> it.pixel_x;
		row  = rows[it.pixel_y];
		case (it.req)
			lms_pkg::REQ_TICK: begin
				r.row_select_bit = (scan_ptr != '0);
				r.row_shift      = 1'b1;
				r.column_data    = rows[scan_ptr ^ lms_pkg::SCAN_FLIP];
				scan_ptr         = scan_ptr + 3'd1;
			end
			lms_pkg::REQ_SET: begin
				r.pixel_was       = |(row & mask);
				rows[it.pixel_y] = row | mask;
			end
			lms_pkg::REQ_CLEAR: begin
				r.pixel_was       = |(row & mask);
				rows[it.pixel_y] = row & ~mask;
			end
			lms_pkg::REQ_TOGGLE: begin
				r.pixel_was       = |(row & mask);
				rows[it.pixel_y] = row ^ mask;
			end
			lms_pkg::REQ_GET: begin
				r.pixel_was = |(row & mask);
			end
			lms_pkg::REQ_PUT: begin
				r.pixel_was       = |(row & mask);
				rows[it.pixel_y] = it.put_value ? (row | mask) : (row & ~mask);
			end
			lms_pkg::REQ_CLR_ALL: foreach (rows[i]) rows[i] = '0;
			lms_pkg::REQ_SET_ALL: foreach (rows[i]) rows[i] = lms_pkg::ROW_FULL;
			lms_pkg::REQ_INV_ALL: foreach (rows[i]) rows[i] = rows[i] ^ lms_pkg::ROW_FULL;
			default: ; // unused kinds leave the state alone
		endcase
		due_results.push_back(r);
	endfunction

	// Compare one output word with the oldest prediction
	task check_result(input logic [15:0] word);
		lms_pkg::result_t got;
		lms_pkg::result_t want;
		got = word[10:0];
		if (due_results.size() == 0) begin
			report($sformatf("unexpected word %h", word));
		end else begin
			want = due_results.pop_front();
			if (got.pixel_was !== want.pixel_was)
				report($sformatf("pixel_was %b, want %b", got.pixel_was, want.pixel_was));
			if (got.row_select_bit !== want.row_select_bit)
				report($sformatf("row_select_bit %b, want %b",
					got.row_select_bit, want.row_select_bit));
			if (got.row_shift !== want.row_shift)
				report($sformatf("row_shift %b, want %b", got.row_shift, want.row_shift));
			if (got.column_data !== want.column_data)
				report($sformatf("column_data %h, want %h",
					got.column_data, want.column_data));
			if (word[15:11] !== 5'd0)
				report($sformatf("pad bits %b not zero", word[15:11]));
		end
		words_seen++;
	endtask

	task finish_check();
		if (due_results.size() != 0)
			report($sformatf("%0d result words never arrived", due_results.size()));
	endtask
endclass

module tb_top;
	localparam int unsigned STALL_LIMIT  = 2000;
	localparam int unsigned DRAIN_CYCLES = 10;
	localparam int unsigned HOLD_CYCLES  = 64;
	localparam logic [3:0]  KIND_TOP     = 4'hF; // highest request code the field allows

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [3:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;

	matrix_scoreboard sb;
	int unsigned      tx_gap_pct;
	int unsigned      rx_gap_pct;
	int unsigned      hold_request;
	int unsigned      stall_cycles;

	led_matrix_scan_framebuffer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Sample both handshakes at the rising edge
	always @(posedge clk) begin
		lms_pkg::item_t it;
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if (s_tvalid && s_tready) begin
				it.req       = lms_pkg::req_t'(s_tuser);
				it.pixel_x   = s_tdata[2:0];
				it.pixel_y   = s_tdata[5:3];
				it.put_value = s_tdata[6];
				sb.note_request(it);
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off when asked
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		m_tready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99, 0) >= rx_gap_pct);
			end
		end
	end

	// Watchdog: cycles with no word moving on either side
	initial begin
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("tb_top NOT OK");
		$finish;
	end

	// Offer one request word; called and returns at a falling edge
	task automatic send_request(input logic [3:0] kind, input logic [2:0] px,
			input logic [2:0] py, input logic pv);
		while ($urandom_range(99, 0) < tx_gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {1'b0, pv, py, px};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// Random mix weighted toward pixel work and ticks
	task automatic send_random();
		int unsigned pick;
		logic [3:0]  kind;
		pick = $urandom_range(99, 0);
		if (pick < 28)
			kind = lms_pkg::REQ_TICK;
		else if (pick < 90)
			kind = 4'($urandom_range(lms_pkg::REQ_PUT, lms_pkg::REQ_SET));
		else if (pick < 96)
			kind = 4'($urandom_range(lms_pkg::REQ_INV_ALL, lms_pkg::REQ_CLR_ALL));
		else
			kind = 4'($urandom_range(KIND_TOP, lms_pkg::REQ_INV_ALL + 1));
		send_request(kind, 3'($urandom_range(7, 0)), 3'($urandom_range(7, 0)),
			1'($urandom_range(1, 0)));
	endtask

	initial begin
		sb           = new();
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = '0;
		hold_request = 0;
		tx_gap_pct   = 0;
		rx_gap_pct   = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty frame, corner pixels, every request kind
		send_request(lms_pkg::REQ_TICK,    3'd0, 3'd0, 1'b0); // scan start, empty row
		send_request(lms_pkg::REQ_GET,     3'd0, 3'd0, 1'b0);
		send_request(lms_pkg::REQ_SET,     3'd0, 3'd0, 1'b0); // x=0 lands on bit 7
		send_request(lms_pkg::REQ_SET,     3'd0, 3'd0, 1'b1); // already lit
		send_request(lms_pkg::REQ_SET,     3'd7, 3'd7, 1'b1);
		send_request(lms_pkg::REQ_GET,     3'd7, 3'd7, 1'b1);
		send_request(lms_pkg::REQ_TOGGLE,  3'd3, 3'd5, 1'b0);
		send_request(lms_pkg::REQ_TOGGLE,  3'd3, 3'd5, 1'b1);
		send_request(lms_pkg::REQ_CLEAR,   3'd0, 3'd0, 1'b1);
		send_request(lms_pkg::REQ_CLEAR,   3'd0, 3'd0, 1'b0);
		send_request(lms_pkg::REQ_PUT,     3'd4, 3'd2, 1'b1);
		send_request(lms_pkg::REQ_PUT,     3'd4, 3'd2, 1'b0);
		send_request(lms_pkg::REQ_PUT,     3'd4, 3'd2, 1'b0);
		send_request(lms_pkg::REQ_SET,     3'd5, 3'd2, 1'b0);
		send_request(lms_pkg::REQ_TICK,    3'd7, 3'd7, 1'b1); // pointer 1 reads row 2
		send_request(lms_pkg::REQ_SET_ALL, 3'd0, 3'd0, 1'b0);
		send_request(lms_pkg::REQ_GET,     3'd5, 3'd6, 1'b0);
		send_request(lms_pkg::REQ_INV_ALL, 3'd7, 3'd7, 1'b1);
		send_request(lms_pkg::REQ_TICK,    3'd0, 3'd0, 1'b0);
		send_request(lms_pkg::REQ_INV_ALL, 3'd0, 3'd0, 1'b0);
		send_request(lms_pkg::REQ_TICK,    3'd0, 3'd0, 1'b0); // full row
		send_request(lms_pkg::REQ_CLR_ALL, 3'd2, 3'd4, 1'b1);
		send_request(4'(lms_pkg::REQ_INV_ALL + 1), 3'd7, 3'd7, 1'b1); // unused kinds
		send_request(KIND_TOP,             3'd5, 3'd3, 1'b1);

		// Random: sender rarely idles, receiver often stalls
		tx_gap_pct   = 6;
		rx_gap_pct   = 66;
		hold_request = HOLD_CYCLES;
		repeat (360) send_random();

		// Random: the other way round
		tx_gap_pct   = 66;
		rx_gap_pct   = 6;
		hold_request = HOLD_CYCLES;
		repeat (360) send_random();

		// Random: full rate both sides, one long back-pressure stretch
		tx_gap_pct   = 0;
		rx_gap_pct   = 0;
		hold_request = HOLD_CYCLES;
		repeat (380) send_random();
		s_tvalid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.finish_check();
		if (sb.fail_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end
endmodule
